FILE: rtl/ssdw_pkg.sv
// shared constants, request codes and the segment glyph table for the
// seven-segment display writer; no dependencies
package ssdw_pkg;

  localparam int DIGITS  = 4;
  localparam int VAL_W   = 16;
  localparam int BASE_W  = 5;
  localparam int DIGIT_W = 4;
  localparam int IDX_W   = $clog2(DIGITS + 1);
  localparam int DCNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CNT_W   = $clog2(VAL_W);

  localparam logic [7:0] BASE_MIN = 8'd2;
  localparam logic [7:0] BASE_MAX = 8'd16;
  localparam logic [7:0] ADDR_CMD = 8'hC0;
  localparam logic [7:0] CTRL_CMD = 8'h80;

  typedef enum logic [1:0] {
    CMD_NUMBER   = 2'd0,
    CMD_DIGIT    = 2'd1,
    CMD_CONTRAST = 2'd2,
    CMD_SHOW     = 2'd3
  } cmd_e;

  function automatic logic [7:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [7:0] g;
    unique case (d)
      4'h0: g = 8'h3F;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5B;
      4'h3: g = 8'h4F;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6D;
      4'h6: g = 8'h7D;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7F;
      4'h9: g = 8'h6F;
      4'hA: g = 8'h77;
      4'hB: g = 8'h7C;
      4'hC: g = 8'h39;
      4'hD: g = 8'h5E;
      4'hE: g = 8'h79;
      default: g = 8'h71;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/ssdw_div.sv
// bit-serial restoring divider: one quotient bit per cycle, gives one digit
// (remainder) and the quotient for the next digit; uses ssdw_pkg
module ssdw_div import ssdw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [VAL_W-1:0]   dividend_i,
  input  logic [BASE_W-1:0]  divisor_i,
  output logic               done_o,
  output logic [VAL_W-1:0]   quot_o,
  output logic [DIGIT_W-1:0] rem_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [VAL_W-1:0]   quot_q, quot_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [BASE_W-1:0]  trial;
  logic               fits;

  // remainder stays below the divisor, so it fits in one digit
  assign trial = {rem_q, quot_q[VAL_W-1]};
  assign fits  = trial >= divisor_i;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quot_d = {quot_q[VAL_W-2:0], fits};
      rem_d  = fits ? DIGIT_W'(trial - divisor_i) : DIGIT_W'(trial);
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(VAL_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/seven_segment_display_writer.sv
// top level of the seven-segment display writer: request decode, digit
// extraction through ssdw_div, and the registered word output; uses ssdw_pkg
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+----------------------------------------
//   in      | in_valid_i | in_stall_o  | command, value, number_base, pattern...
//   out     | out_valid_o| out_stall_i | bus_byte, byte_valid, starts_frame ...
//
// write number: DIGITS digits, each from the bit-serial divider, then
// DIGITS+1 words; other requests skip the divider and go straight to
// the words they produce.
// in_stall_o is high while a request is being worked on; the last word may
// still sit in the output register while the next request is accepted.
// reset puts the display flag off and the brightness code at 3.
module seven_segment_display_writer import ssdw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] value_i,
  input  logic [7:0]  number_base_i,
  input  logic [7:0]  segment_pattern_i,
  input  logic [7:0]  digit_position_i,
  input  logic        show_dot_i,
  input  logic [2:0]  contrast_i,
  input  logic        display_on_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  bus_byte_o,
  output logic        byte_valid_o,
  output logic        starts_frame_o,
  output logic        arg_error_o,
  output logic        last_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic               shown_q, shown_d;
  logic [2:0]         bright_q, bright_d;
  logic               err_q, err_d;
  logic               numeric_q, numeric_d;
  logic [7:0]         hdr_q, hdr_d;
  logic [7:0]         pat_q, pat_d;
  logic [BASE_W-1:0]  base_q, base_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   nlast_q, nlast_d;
  logic [DCNT_W-1:0]  dcnt_q, dcnt_d;
  logic [DIGIT_W-1:0] dig_q [DIGITS];
  logic [DIGIT_W-1:0] dig_d [DIGITS];

  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q, obyte_d;
  logic       obv_q, obv_d;
  logic       ostart_q, ostart_d;
  logic       oerr_q, oerr_d;
  logic       olast_q, olast_d;

  logic               accept;
  logic               out_free;
  logic               bad_base;
  logic               bad_pos;
  logic               div_start;
  logic [VAL_W-1:0]   div_dividend;
  logic               div_done;
  logic [VAL_W-1:0]   div_quot;
  logic [DIGIT_W-1:0] div_rem;
  logic               res_last;
  logic [7:0]         res_byte;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !ovalid_q || !out_stall_i;

  assign bad_base = (number_base_i < BASE_MIN) || (number_base_i > BASE_MAX);
  assign bad_pos  = (digit_position_i == 8'd0) || (digit_position_i > 8'(DIGITS));

  assign div_dividend = (state_q == ST_IDLE) ? value_i : div_quot;
  assign div_start = (accept && cmd_e'(command_i) == CMD_NUMBER && !bad_base) ||
                     (state_q == ST_DIVIDE && div_done &&
                      dcnt_q != DCNT_W'(DIGITS - 1));

  ssdw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (base_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign res_last = (idx_q == nlast_q);
  always_comb begin
    if (idx_q == '0) begin
      res_byte = hdr_q;
    end else if (numeric_q) begin
      res_byte = glyph(dig_q[DIGITS-1]);
    end else begin
      res_byte = pat_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    shown_d   = shown_q;
    bright_d  = bright_q;
    err_d     = err_q;
    numeric_d = numeric_q;
    hdr_d     = hdr_q;
    pat_d     = pat_q;
    base_d    = base_q;
    idx_d     = idx_q;
    nlast_d   = nlast_q;
    dcnt_d    = dcnt_q;
    dig_d     = dig_q;
    ovalid_d  = ovalid_q && out_stall_i;
    obyte_d   = obyte_q;
    obv_d     = obv_q;
    ostart_d  = ostart_q;
    oerr_d    = oerr_q;
    olast_d   = olast_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d     = '0;
          dcnt_d    = '0;
          err_d     = 1'b0;
          numeric_d = 1'b0;
          nlast_d   = '0;
          base_d    = BASE_W'(number_base_i);
          pat_d     = segment_pattern_i | {show_dot_i, 7'd0};
          state_d   = ST_EMIT;
          unique case (cmd_e'(command_i))
            CMD_NUMBER: begin
              hdr_d = ADDR_CMD;
              if (bad_base) begin
                err_d = 1'b1;
              end else begin
                numeric_d = 1'b1;
                nlast_d   = IDX_W'(DIGITS);
                state_d   = ST_DIVIDE;
              end
            end
            CMD_DIGIT: begin
              hdr_d = ADDR_CMD | (digit_position_i - 8'd1);
              if (bad_pos) begin
                err_d = 1'b1;
              end else begin
                nlast_d = IDX_W'(1);
              end
            end
            CMD_CONTRAST: begin
              hdr_d    = CTRL_CMD | {4'd0, shown_q, contrast_i};
              bright_d = contrast_i;
            end
            CMD_SHOW: begin
              hdr_d   = CTRL_CMD | {4'd0, display_on_i, bright_q};
              shown_d = display_on_i;
            end
            default: begin
              hdr_d = CTRL_CMD;
            end
          endcase
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          // digits arrive least significant first, enter at the top and shift down
          for (int i = 0; i < DIGITS - 1; i++) begin
            dig_d[i] = dig_q[i+1];
          end
          dig_d[DIGITS-1] = div_rem;
          dcnt_d = dcnt_q + DCNT_W'(1);
          if (dcnt_q == DCNT_W'(DIGITS - 1)) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obyte_d  = err_q ? 8'd0 : res_byte;
          obv_d    = !err_q;
          ostart_d = !err_q && (idx_q == '0);
          oerr_d   = err_q;
          olast_d  = res_last;
          idx_d    = idx_q + IDX_W'(1);
          if (numeric_q && idx_q != '0) begin
            for (int i = DIGITS - 1; i > 0; i--) begin
              dig_d[i] = dig_q[i-1];
            end
          end
          if (res_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      shown_q  <= 1'b0;
      bright_q <= 3'd3;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
      nlast_q  <= '0;
      dcnt_q   <= '0;
      err_q    <= 1'b0;
      numeric_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      shown_q  <= shown_d;
      bright_q <= bright_d;
      ovalid_q <= ovalid_d;
      idx_q    <= idx_d;
      nlast_q  <= nlast_d;
      dcnt_q   <= dcnt_d;
      err_q    <= err_d;
      numeric_q <= numeric_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q    <= hdr_d;
    pat_q    <= pat_d;
    base_q   <= base_d;
    dig_q    <= dig_d;
    obyte_q  <= obyte_d;
    obv_q    <= obv_d;
    ostart_q <= ostart_d;
    oerr_q   <= oerr_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o    = ovalid_q;
  assign bus_byte_o     = obyte_q;
  assign byte_valid_o   = obv_q;
  assign starts_frame_o = ostart_q;
  assign arg_error_o    = oerr_q;
  assign last_o         = olast_q;

endmodule

FILE: rtl/ssdw_checker.sv
// port-level checks for the seven-segment display writer, bound to the top
// level; no package dependencies
module ssdw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] bus_byte_o,
  input logic       byte_valid_o,
  input logic       starts_frame_o,
  input logic       arg_error_o,
  input logic       last_o
);

  // the input stays stalled in the cycle after a request is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted word");

  // words of one frame follow without gaps, and only the first starts it
  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && !starts_frame_o)
    else $error("frame broken after non-final word");

  a_error_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arg_error_o |-> last_o && !byte_valid_o && !starts_frame_o)
    else $error("error word malformed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bus_byte_o))
    else $error("stalled output word changed");

endmodule

bind seven_segment_display_writer ssdw_checker u_ssdw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .bus_byte_o     (bus_byte_o),
  .byte_valid_o   (byte_valid_o),
  .starts_frame_o (starts_frame_o),
  .arg_error_o    (arg_error_o),
  .last_o         (last_o)
);

FILE: bench/seven_segment_display_writer_tb.sv
// self-checking bench for seven_segment_display_writer: random-paced driver
// and monitor, in-bench frame encoder that predicts every bus word
// depends on ssdw_pkg and the rtl top level only
module seven_segment_display_writer_tb import ssdw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS = 410;
  localparam int QUIET_LIMIT = 3000;

  localparam logic [7:0] SEG_FONT [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  typedef struct packed {
    cmd_e        command;
    logic [15:0] value;
    logic [7:0]  base;
    logic [7:0]  pattern;
    logic [7:0]  position;
    logic        dot;
    logic [2:0]  contrast;
    logic        on;
  } request_t;

  typedef struct {
    request_t req;
    bit       drain;  // hold this request back until the bus is quiet
  } pending_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       byte_valid;
    logic       starts_frame;
    logic       arg_error;
    logic       last;
  } bus_word_t;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  request_t  req_d = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  bus_word_t word_q;

  pending_t  pending_q[$];
  bus_word_t bus_words_q[$];
  int        send_gap = 0;
  int        recv_wait = 0;
  bit        send_calm = 1'b0;
  bit        recv_calm = 1'b0;
  int        quiet_cycles = 0;
  int        failures = 0;

  // display state as the chip sees it
  logic       disp_on = 1'b0;
  logic [2:0] bright = 3'd3;

  seven_segment_display_writer uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .command_i         (req_d.command),
    .value_i           (req_d.value),
    .number_base_i     (req_d.base),
    .segment_pattern_i (req_d.pattern),
    .digit_position_i  (req_d.position),
    .show_dot_i        (req_d.dot),
    .contrast_i        (req_d.contrast),
    .display_on_i      (req_d.on),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .bus_byte_o        (word_q.bus_byte),
    .byte_valid_o      (word_q.byte_valid),
    .starts_frame_o    (word_q.starts_frame),
    .arg_error_o       (word_q.arg_error),
    .last_o            (word_q.last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void emit(input logic [7:0] b, input logic v, input logic s,
                               input logic e, input logic l);
    bus_words_q.push_back('{bus_byte: b, byte_valid: v, starts_frame: s,
                            arg_error: e, last: l});
  endfunction

  // frame encoder: turns one request into the words of its bus frame
  function automatic void encode_request(input request_t r);
    logic [15:0] v;
    logic [7:0]  glyphs [DIGITS];
    case (r.command)
      CMD_NUMBER: begin
        if (r.base < BASE_MIN || r.base > BASE_MAX) begin
          emit(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        end else begin
          v = r.value;
          for (int i = 0; i < DIGITS; i++) begin
            glyphs[i] = SEG_FONT[v % r.base];
            v = v / r.base;
          end
          emit(ADDR_CMD, 1'b1, 1'b1, 1'b0, 1'b0);
          for (int i = DIGITS - 1; i >= 0; i--) begin
            emit(glyphs[i], 1'b1, 1'b0, 1'b0, i == 0);
          end
        end
      end
      CMD_DIGIT: begin
        if (r.position == 8'd0 || r.position > DIGITS) begin
          emit(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        end else begin
          emit(ADDR_CMD | (r.position - 8'd1), 1'b1, 1'b1, 1'b0, 1'b0);
          emit(r.dot ? (r.pattern | 8'h80) : r.pattern, 1'b1, 1'b0, 1'b0, 1'b1);
        end
      end
      CMD_CONTRAST: begin
        emit(CTRL_CMD | {4'b0, disp_on, r.contrast}, 1'b1, 1'b1, 1'b0, 1'b1);
        bright = r.contrast;
      end
      default: begin
        emit(CTRL_CMD | {4'b0, r.on, bright}, 1'b1, 1'b1, 1'b0, 1'b1);
        disp_on = r.on;
      end
    endcase
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 3));
  endfunction

  function automatic request_t mk(input cmd_e c, input logic [15:0] val,
                                  input logic [7:0] base, input logic [7:0] pat,
                                  input logic [7:0] pos, input logic dot,
                                  input logic [2:0] con, input logic on);
    return '{command: c, value: val, base: base, pattern: pat, position: pos,
             dot: dot, contrast: con, on: on};
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.command = cmd_e'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       r.value = 16'h0000;
      1:       r.value = 16'hFFFF;
      default: r.value = 16'($urandom);
    endcase
    // mostly legal bases and positions so frames actually go out
    r.base     = ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'($urandom_range(2, 16));
    r.position = ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'($urandom_range(1, DIGITS));
    r.pattern  = 8'($urandom);
    r.dot      = 1'($urandom);
    r.contrast = 3'($urandom);
    r.on       = 1'($urandom);
    return r;
  endfunction

  function automatic void add(input request_t r, input bit drain);
    pending_q.push_back('{req: r, drain: drain});
  endfunction

  function automatic void match(input string name, input logic [7:0] want,
                                input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin : drive_p
      int gap;
      gap = send_gap;
      if (in_valid) begin
        encode_request(req_d);
        gap = draw_wait(send_calm);
        if ($urandom_range(0, 29) == 0) send_calm <= !send_calm;
      end
      if (gap > 0) begin
        send_gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   (!pending_q[0].drain || bus_words_q.size() == 0)) begin
        req_d    <= pending_q[0].req;
        void'(pending_q.pop_front());
        send_gap <= 0;
        in_valid <= 1'b1;
      end else begin
        send_gap <= 0;
        in_valid <= 1'b0;
      end
    end
  end

  // word monitor and checker
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
    end else begin : check_p
      int w;
      bus_word_t want;
      w = recv_wait;
      if (out_valid && !out_stall) begin
        if (bus_words_q.size() == 0) begin
          $error("unexpected word, bus_byte %0h", word_q.bus_byte);
          failures++;
        end else begin
          want = bus_words_q.pop_front();
          match("bus_byte", want.bus_byte, word_q.bus_byte);
          match("byte_valid", want.byte_valid, word_q.byte_valid);
          match("starts_frame", want.starts_frame, word_q.starts_frame);
          match("arg_error", want.arg_error, word_q.arg_error);
          match("last", want.last, word_q.last);
        end
        w = draw_wait(recv_calm);
        if ($urandom_range(0, 29) == 0) recv_calm <= !recv_calm;
      end else if (w > 0) begin
        w--;
      end
      recv_wait <= w;
      out_stall <= (w > 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("seven_segment_display_writer test failed");
    $finish;
  end

  initial begin
    // display control first, from the reset state
    add(mk(CMD_SHOW,     16'h0000, 8'd0,   8'h00, 8'd0,   1'b0, 3'd0, 1'b1), 1'b0);
    add(mk(CMD_CONTRAST, 16'h0000, 8'd0,   8'h00, 8'd0,   1'b0, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_CONTRAST, 16'h0000, 8'd0,   8'h00, 8'd0,   1'b0, 3'd7, 1'b0), 1'b0);
    add(mk(CMD_SHOW,     16'hFFFF, 8'hFF,  8'hFF, 8'hFF,  1'b1, 3'd7, 1'b0), 1'b0);
    add(mk(CMD_CONTRAST, 16'h0000, 8'd0,   8'h00, 8'd0,   1'b0, 3'd5, 1'b1), 1'b0);
    // number writes across bases, then every kind of bad base
    add(mk(CMD_NUMBER,   16'h0000, 8'd16,  8'h00, 8'd0,   1'b0, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_NUMBER,   16'hFFFF, 8'd16,  8'h00, 8'd0,   1'b0, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_NUMBER,   16'hFFFF, 8'd2,   8'h00, 8'd0,   1'b0, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_NUMBER,   16'd1234, 8'd10,  8'h00, 8'd0,   1'b0, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_NUMBER,   16'hFFFF, 8'd3,   8'h00, 8'd0,   1'b0, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_NUMBER,   16'd5,    8'd1,   8'h00, 8'd0,   1'b0, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_NUMBER,   16'd5,    8'd0,   8'h00, 8'd0,   1'b0, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_NUMBER,   16'd5,    8'd17,  8'h00, 8'd0,   1'b0, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_NUMBER,   16'd5,    8'd255, 8'h00, 8'd0,   1'b0, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_NUMBER,   16'hA5C3, 8'd16,  8'hFF, 8'hFF,  1'b1, 3'd7, 1'b1), 1'b0);
    // single digit writes, dot on and off, every kind of bad position
    add(mk(CMD_DIGIT,    16'h0000, 8'd0,   8'h00, 8'd1,   1'b1, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_DIGIT,    16'hFFFF, 8'hFF,  8'hFF, 8'd4,   1'b0, 3'd7, 1'b1), 1'b0);
    add(mk(CMD_DIGIT,    16'h0000, 8'd0,   8'h55, 8'd2,   1'b0, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_DIGIT,    16'h0000, 8'd0,   8'h2A, 8'd3,   1'b1, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_DIGIT,    16'h0000, 8'd0,   8'h12, 8'd0,   1'b1, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_DIGIT,    16'h0000, 8'd0,   8'h12, 8'd5,   1'b0, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_DIGIT,    16'h0000, 8'd0,   8'h12, 8'd255, 1'b0, 3'd0, 1'b0), 1'b0);
    add(mk(CMD_SHOW,     16'h0000, 8'd0,   8'h00, 8'd0,   1'b0, 3'd0, 1'b1), 1'b1);
    add(mk(CMD_NUMBER,   16'd12345, 8'd7,  8'h00, 8'd0,   1'b0, 3'd0, 1'b0), 1'b0);
    for (int i = 0; i < RANDOM_REQS; i++) begin
      add(random_request(), $urandom_range(0, 39) == 0);
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    while (pending_q.size() != 0 || in_valid || bus_words_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (100) @(negedge clk_i);
    if (failures == 0 && bus_words_q.size() == 0) begin
      $display("seven_segment_display_writer test passed");
    end else begin
      $display("seven_segment_display_writer test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ssdw_pkg.sv
rtl/ssdw_div.sv
rtl/seven_segment_display_writer.sv
rtl/ssdw_checker.sv
bench/seven_segment_display_writer_tb.sv
